// ----- sv/rbf_pkg.sv -----
// Shared types and constants for the RGB 3x3 box filter.
// No dependencies; all files but rbf_line_mem import this package.
`default_nettype none

package rbf_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int COORD_W    = 10;
  localparam int SUM_W      = 12;
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_W  = 2;

  // floor(sum / 9) == (sum * 7282) >> 16 for every sum of nine bytes
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int WIDTH_RESET  = 320;
  localparam int HEIGHT_RESET = 240;
  localparam int DIM_MIN      = 3;

  typedef logic [PIX_W-1:0]   pixel_t;
  typedef logic [COORD_W-1:0] coord_val_t;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_t;

  typedef struct packed {
    coord_val_t      out_row;
    coord_val_t      out_col;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_of_run;
  } out_t;

  // position of a request within the frame
  typedef struct packed {
    logic row0;
    logic row_ge2;
    logic col0;
    logic col1;
    logic col_last;
    logic row_last;
  } pos_t;

  // output coordinates of a request, already cut to the output width
  typedef struct packed {
    coord_val_t row;
    coord_val_t row_m1;
    coord_val_t col;
    coord_val_t col_m1;
  } coords_t;

  typedef struct packed {
    coord_val_t row;
    coord_val_t col;
    pixel_t     px;
  } res_t;

  // all results caused by one request; only entry 0 can be filtered
  typedef struct packed {
    logic [RES_CNT_W-1:0]           cnt;
    logic                           filt;
    logic [NUM_CH-1:0][SUM_W-1:0]   sums;
    res_t [MAX_RES-1:0]             ent;
  } bundle_t;

  function automatic pixel_t pack_px(in_t d);
    return {d.blue_in, d.green_in, d.red_in};
  endfunction

endpackage

`default_nettype wire

// ----- sv/rbf_line_mem.sv -----
// Line store RAM: upper and middle line side by side, one word per column.
// One write and one registered read port; uses no package.
`default_nettype none

module rbf_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 48
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/rbf_window.sv -----
// Window stage: holds one request, combines it with the line store read and
// the 2x3 window into a result bundle, and writes the rotated lines back. Uses rbf_pkg.
`default_nettype none

module rbf_window import rbf_pkg::*; #(
  parameter int ADDR_W = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire pixel_t               ld_px,
  input  wire pos_t                 ld_pos,
  input  wire coords_t              ld_coord,
  input  wire logic [ADDR_W-1:0]    ld_addr,
  input  wire logic [2*PIX_W-1:0]   rd_data,
  input  wire logic                 bund_ready,
  output logic                      s1_valid,
  output logic                      s1_adv,
  output logic                      bund_valid,
  output bundle_t                   bund,
  output logic                      wr_en,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [2*PIX_W-1:0]        wr_data
);

  logic              s1_v_r;
  pixel_t            px_r;
  pos_t              pos_r;
  coords_t           coord_r;
  logic [ADDR_W-1:0] addr_r;
  pixel_t            win_r [6];

  pixel_t  top;
  pixel_t  mid;
  bundle_t b;

  assign top = rd_data[2*PIX_W-1:PIX_W];
  assign mid = rd_data[PIX_W-1:0];

  always_comb begin
    b = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      b.sums[ch] = ((SUM_W'(win_r[0][ch*CH_W +: CH_W]) + SUM_W'(win_r[1][ch*CH_W +: CH_W]))
                 + (SUM_W'(win_r[2][ch*CH_W +: CH_W]) + SUM_W'(win_r[3][ch*CH_W +: CH_W])))
                 + ((SUM_W'(win_r[4][ch*CH_W +: CH_W]) + SUM_W'(win_r[5][ch*CH_W +: CH_W]))
                 + (SUM_W'(top[ch*CH_W +: CH_W]) + SUM_W'(mid[ch*CH_W +: CH_W])))
                 + SUM_W'(px_r[ch*CH_W +: CH_W]);
    end
    if (pos_r.row0) begin
      b.ent[b.cnt] = '{row: coord_r.row, col: coord_r.col, px: px_r};
      b.cnt        = b.cnt + RES_CNT_W'(1);
    end else if (pos_r.row_ge2) begin
      if (!pos_r.col0) begin
        // left border of the row above passes through from the window
        if (pos_r.col1) begin
          b.ent[b.cnt] = '{row: coord_r.row_m1, col: coord_r.col_m1, px: win_r[4]};
        end else begin
          b.filt       = 1'b1;
          b.ent[b.cnt] = '{row: coord_r.row_m1, col: coord_r.col_m1, px: '0};
        end
        b.cnt = b.cnt + RES_CNT_W'(1);
        if (pos_r.col_last) begin
          b.ent[b.cnt] = '{row: coord_r.row_m1, col: coord_r.col, px: mid};
          b.cnt        = b.cnt + RES_CNT_W'(1);
        end
      end
      if (pos_r.row_last) begin
        b.ent[b.cnt] = '{row: coord_r.row, col: coord_r.col, px: px_r};
        b.cnt        = b.cnt + RES_CNT_W'(1);
      end
    end
  end

  // a request that causes no result leaves without waiting for the emitter
  assign s1_adv     = s1_v_r && ((b.cnt == '0) || bund_ready);
  assign s1_valid   = s1_v_r;
  assign bund_valid = s1_v_r && (b.cnt != '0);
  assign bund       = b;

  // columns repeat only every image width (at least three requests), so the
  // write back always lands before the next read of the same column
  assign wr_en   = s1_adv;
  assign wr_addr = addr_r;
  assign wr_data = {mid, px_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (load) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top;
        win_r[4] <= mid;
        win_r[5] <= px_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r    <= ld_px;
      pos_r   <= ld_pos;
      coord_r <= ld_coord;
      addr_r  <= ld_addr;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rbf_emit.sv -----
// Result emitter: holds one bundle, sends one result per ready cycle via
// an output register and divides the filtered sums by nine. Uses rbf_pkg.
`default_nettype none

module rbf_emit import rbf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    bund_valid,
  input  wire bundle_t bund,
  output logic         bund_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_t         out_data
);

  logic                 s2_v_r;
  bundle_t              b_r;
  logic [RES_CNT_W-1:0] ptr_r;
  logic                 out_v_r;
  out_t                 out_r;

  logic                 ld;
  logic                 take;
  logic                 last;
  res_t                 e;
  pixel_t               px;
  logic [SUM_W+RECIP_W-1:0] prod [NUM_CH];
  out_t                 out_nxt;

  assign ld   = !out_v_r || out_ready;
  assign take = s2_v_r && ld;
  assign last = (ptr_r == b_r.cnt - RES_CNT_W'(1));

  assign bund_ready = !s2_v_r || (take && last);

  always_comb begin
    e  = b_r.ent[ptr_r];
    px = e.px;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = (SUM_W+RECIP_W)'(b_r.sums[ch]) * (SUM_W+RECIP_W)'(RECIP9);
      if (b_r.filt && (ptr_r == '0)) begin
        px[ch*CH_W +: CH_W] = prod[ch][RECIP_SHIFT +: CH_W];
      end
    end
    out_nxt.out_row     = e.row;
    out_nxt.out_col     = e.col;
    out_nxt.red_out     = px[0*CH_W +: CH_W];
    out_nxt.green_out   = px[1*CH_W +: CH_W];
    out_nxt.blue_out    = px[2*CH_W +: CH_W];
    out_nxt.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      ptr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (ld) begin
        out_v_r <= take;
      end
      if (bund_ready) begin
        s2_v_r <= bund_valid;
        ptr_r  <= '0;
      end else if (take) begin
        ptr_r <= ptr_r + RES_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bund_ready) begin
      b_r <= bund;
    end
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- sv/rgb_box_filter_3x3.sv -----
// RGB 3x3 box filter. A pixel passes the window request register, the emitter's bundle
// register and the output register. Throughput: 1 pixel per cycle while out_ready is high;
// a pixel with two or three results (last row, right column) stalls the input as they leave.
// Reset: position returns to row 0 column 0, geometry to 320x240 (clamped to the maximum);
// the line store RAM is not cleared and needs no clearing pass.
// Depends on rbf_pkg, rbf_line_mem, rbf_window and rbf_emit.
`default_nettype none

module rgb_box_filter_3x3 import rbf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int H_RESET = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  logic [DW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [DW-1:0] w_clamp;
  logic [HW-1:0] h_clamp;

  logic    accept;
  pos_t    pos;
  coords_t coord;

  logic                s1_valid;
  logic                s1_adv;
  logic                bund_valid;
  bundle_t             bund;
  logic                bund_ready;
  logic [2*PIX_W-1:0]  rd_data;
  logic                wr_en;
  logic [CW-1:0]       wr_addr;
  logic [2*PIX_W-1:0]  wr_data;

  always_comb begin
    if (int'(cfg_wdata) < DIM_MIN) begin
      w_clamp = DW'(DIM_MIN);
    end else if (int'(cfg_wdata) > MAX_WIDTH) begin
      w_clamp = DW'(MAX_WIDTH);
    end else begin
      w_clamp = DW'(cfg_wdata);
    end
    if (int'(cfg_wdata) < DIM_MIN) begin
      h_clamp = HW'(DIM_MIN);
    end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(cfg_wdata);
    end
  end

  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos.row0     = (row_r == '0);
    pos.row_ge2  = (row_r >= RW'(2));
    pos.col0     = (col_r == '0);
    pos.col1     = (col_r == CW'(1));
    pos.col_last = (DW'(col_r) == w_r - DW'(1));
    pos.row_last = (HW'(row_r) == h_r - HW'(1));
    coord.row    = COORD_W'(row_r);
    coord.row_m1 = COORD_W'(row_r - RW'(1));
    coord.col    = COORD_W'(col_r);
    coord.col_m1 = COORD_W'(col_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= DW'(W_RESET);
      h_r   <= HW'(H_RESET);
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we) begin
      // geometry write restarts the frame; unknown indexes are dropped
      if (cfg_addr == CFG_IMAGE_WIDTH) begin
        w_r   <= w_clamp;
        col_r <= '0;
        row_r <= '0;
      end else if (cfg_addr == CFG_IMAGE_HEIGHT) begin
        h_r   <= h_clamp;
        col_r <= '0;
        row_r <= '0;
      end
    end else if (accept) begin
      if (pos.col_last) begin
        col_r <= '0;
        row_r <= pos.row_last ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  rbf_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2*PIX_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  rbf_window #(
    .ADDR_W (CW)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .ld_px      (pack_px(in_data)),
    .ld_pos     (pos),
    .ld_coord   (coord),
    .ld_addr    (col_r),
    .rd_data    (rd_data),
    .bund_ready (bund_ready),
    .s1_valid   (s1_valid),
    .s1_adv     (s1_adv),
    .bund_valid (bund_valid),
    .bund       (bund),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  rbf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .bund_valid (bund_valid),
    .bund       (bund),
    .bund_ready (bund_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for rgb_box_filter_3x3: random and directed RGB rasters.
// Keeps its own model of the line stores, window and frame position and checks every result.
// Depends on rbf_pkg and the rgb_box_filter_3x3 RTL.
module tb;
  import rbf_pkg::*;

  localparam int FRAME_MAX_W     = 1024;
  localparam int FRAME_MAX_H     = 1024;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 100;
  localparam int WIDE_ITEMS      = 40;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int PRINT_LIMIT     = 40;

  // indexes the block must ignore
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_3 = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // filter model state
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  pixel_t                upper_line_m [FRAME_MAX_W];
  pixel_t                middle_line_m [FRAME_MAX_W];
  pixel_t                win_m [6];
  int unsigned           row_pos;
  int unsigned           col_pos;

  out_t        expected_pixels [$];
  out_t        want_px;
  int          error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned hold_off_asked = 0;
  int unsigned hold_off_seen = 0;
  int          hold_left = 0;
  int          rx_wait = 0;

  rgb_box_filter_3x3 #(
    .MAX_WIDTH (FRAME_MAX_W),
    .MAX_HEIGHT(FRAME_MAX_H)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("rgb_box_filter_3x3 regression: fail");
      $finish;
    end
  end

  function automatic int pick_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned top);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic out_t make_result(int unsigned r, int unsigned c, pixel_t px);
    out_t res;
    res.out_row     = coord_val_t'(r);
    res.out_col     = coord_val_t'(c);
    res.red_out     = px[7:0];
    res.green_out   = px[15:8];
    res.blue_out    = px[23:16];
    res.last_of_run = 1'b0;
    return res;
  endfunction

  // Advance the filter model by one pixel and queue the results it causes.
  function automatic void predict_filter(in_t d);
    int unsigned w, h, r, c, n, sum;
    pixel_t      px, top, mid, avg;
    pixel_t      nb [9];
    out_t        res [3];
    w = clamp_dim(width_reg, FRAME_MAX_W);
    h = clamp_dim(height_reg, FRAME_MAX_H);
    r = row_pos;
    c = col_pos;
    px = {d.blue_in, d.green_in, d.red_in};
    n = 0;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    top = upper_line_m[c];
    mid = middle_line_m[c];
    if (r == 0) begin
      res[n] = make_result(r, c, px);
      n++;
    end else if (r >= 2) begin
      if (c >= 1) begin
        if (c == 1) begin
          res[n] = make_result(r - 1, 0, win_m[4]);
        end else begin
          for (int i = 0; i < 6; i++) nb[i] = win_m[i];
          nb[6] = top;
          nb[7] = mid;
          nb[8] = px;
          for (int ch = 0; ch < NUM_CH; ch++) begin
            sum = 0;
            for (int i = 0; i < 9; i++) sum += nb[i][ch*CH_W +: CH_W];
            avg[ch*CH_W +: CH_W] = CH_W'(sum / 9);
          end
          res[n] = make_result(r - 1, c - 1, avg);
        end
        n++;
        if (c == w - 1) begin
          res[n] = make_result(r - 1, c, mid);
          n++;
        end
      end
      if (r == h - 1) begin
        res[n] = make_result(r, c, px);
        n++;
      end
    end
    // shift the window, rotate the line stores
    win_m[0] = win_m[3];
    win_m[1] = win_m[4];
    win_m[2] = win_m[5];
    win_m[3] = top;
    win_m[4] = mid;
    win_m[5] = px;
    upper_line_m[c]  = mid;
    middle_line_m[c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_pixels.push_back(res[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                             input logic [COORD_W-1:0] want_v);
    if (got !== want_v)
      report_mismatch($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
                                name, want_px.out_row, want_px.out_col, got, want_v));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result at row %0d col %0d with nothing expected",
                                  out_data.out_row, out_data.out_col));
      end else begin
        want_px = expected_pixels.pop_front();
        check_field("row", out_data.out_row, want_px.out_row);
        check_field("col", out_data.out_col, want_px.out_col);
        check_field("red", COORD_W'(out_data.red_out), COORD_W'(want_px.red_out));
        check_field("green", COORD_W'(out_data.green_out), COORD_W'(want_px.green_out));
        check_field("blue", COORD_W'(out_data.blue_out), COORD_W'(want_px.blue_out));
        check_field("last_of_run", COORD_W'(out_data.last_of_run),
                    COORD_W'(want_px.last_of_run));
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_off_asked != hold_off_seen) begin
      hold_off_seen <= hold_off_asked;
      hold_left     <= HOLD_OFF_CYCLES - 1;
      out_ready     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_wait   <= pick_gap(receiver_idle_pct);
    end
  end

  function automatic in_t rand_pixel();
    in_t p;
    p.red_in   = CH_W'($urandom_range(255));
    p.green_in = CH_W'($urandom_range(255));
    p.blue_in  = CH_W'($urandom_range(255));
    if ($urandom_range(7) == 0) p.red_in = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(7) == 0) p.green_in = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(7) == 0) p.blue_in = $urandom_range(1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  // Offer one request and hold it until taken; drop valid only when a gap follows.
  task automatic send_pixel(input in_t px);
    int gap;
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_filter(px);
    gap = pick_gap(sender_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  // Drop valid, drain all expected results, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_reg = val;
        row_pos   = 0;
        col_pos   = 0;
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = val;
        row_pos    = 0;
        col_pos    = 0;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_default_geometry();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    send_pixel(in_t'(24'h000000));
    send_pixel(in_t'(24'hFFFFFF));
    wait_idle();
  endtask

  // Smallest frame: top row, silent row, left/right border, one mean, bottom row.
  task automatic test_min_frame();
    logic [PIX_W-1:0] pat [9];
    pat = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
            24'hFFFFFF, 24'hFFFFFF, 24'h55AA00,
            24'hAA55FF, 24'hFFFFFF, 24'h000000};
    write_reg(CFG_IMAGE_WIDTH, 11'd3);
    write_reg(CFG_IMAGE_HEIGHT, 11'd3);
    sender_idle_pct   = 30;
    receiver_idle_pct = 30;
    for (int i = 0; i < 9; i++) send_pixel(in_t'(pat[i]));
    wait_idle();
  endtask

  // Out-of-range geometry, ignored indexes, restart of the frame mid-way.
  task automatic test_config_corners();
    write_reg(CFG_IMAGE_WIDTH, 11'd1);
    write_reg(CFG_IMAGE_HEIGHT, 11'd0);
    send_random(4);
    wait_idle();
    write_reg(CFG_UNUSED_2, 11'd5);
    write_reg(CFG_UNUSED_3, 11'h7FF);
    send_random(5);
    send_random(4);
    wait_idle();
    write_reg(CFG_IMAGE_HEIGHT, 11'd4);
    send_random(3);
    wait_idle();
  endtask

  // Widest rows: width above the maximum clamps, so the first row runs on without wrapping.
  task automatic test_wide_rows();
    write_reg(CFG_IMAGE_WIDTH, 11'h7FF);
    write_reg(CFG_IMAGE_HEIGHT, 11'd2);
    sender_idle_pct   = 5;
    receiver_idle_pct = 5;
    send_random(WIDE_ITEMS);
    wait_idle();
  endtask

  // Hold off the result side long enough that the block stalls its input.
  task automatic test_backpressure();
    write_reg(CFG_IMAGE_WIDTH, 11'd5);
    write_reg(CFG_IMAGE_HEIGHT, 11'd4);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_off_asked <= hold_off_asked + 1;
    send_random(40);
    wait_idle();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim(int unsigned top);
    case ($urandom_range(9))
      0: return CFG_DATA_W'($urandom_range(DIM_MIN - 1));
      1: return CFG_DATA_W'($urandom_range(9, 24));
      2: return CFG_DATA_W'($urandom_range(1) ? top : $urandom_range(top + 1, 2047));
      default: return CFG_DATA_W'($urandom_range(DIM_MIN, 7));
    endcase
  endfunction

  // Mostly whole small frames with random content; some partial runs and restarts.
  task automatic test_random_frames();
    int unsigned sent, count, frame_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(3) != 0) write_reg(CFG_IMAGE_WIDTH, pick_dim(FRAME_MAX_W));
      if ($urandom_range(3) != 0) write_reg(CFG_IMAGE_HEIGHT, pick_dim(FRAME_MAX_H));
      if ($urandom_range(9) == 0) write_reg(CFG_UNUSED_2, CFG_DATA_W'($urandom_range(2047)));
      sender_idle_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
      receiver_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
      frame_len = clamp_dim(width_reg, FRAME_MAX_W) * clamp_dim(height_reg, FRAME_MAX_H);
      if (frame_len <= 64 && $urandom_range(3) != 0) count = frame_len * $urandom_range(1, 2);
      else count = $urandom_range(4, 30);
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      send_random(count);
      sent += count;
      wait_idle();
    end
  endtask

  initial begin
    width_reg  = CFG_DATA_W'(WIDTH_RESET);
    height_reg = CFG_DATA_W'(HEIGHT_RESET);
    row_pos    = 0;
    col_pos    = 0;
    for (int i = 0; i < FRAME_MAX_W; i++) begin
      upper_line_m[i]  = '0;
      middle_line_m[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_m[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_geometry();
    test_min_frame();
    test_config_corners();
    test_wide_rows();
    test_backpressure();
    test_random_frames();
    wait_idle();

    if (error_count == 0) begin
      $display("rgb_box_filter_3x3 regression: pass");
    end else begin
      $display("rgb_box_filter_3x3 regression: fail");
    end
    $finish;
  end

endmodule
